### src/lps_pkg.sv
package lps_pkg;

  // Default geometry of the coordinate and address datapaths.
  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_ADDR_BITS  = 24;

  // Fixed widths of the configuration registers and the colour word.
  localparam int CLIP_BITS  = 12;
  localparam int PITCH_BITS = 13;
  localparam int COLOR_BITS = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  // Item function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_HEIGHT = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_PITCH   = 2'd3;

  // Register values after reset.
  localparam logic                  CLIP_ENABLE_RESET = 1'b1;
  localparam logic [CLIP_BITS-1:0]  CLIP_WIDTH_RESET  = 12'd640;
  localparam logic [CLIP_BITS-1:0]  CLIP_HEIGHT_RESET = 12'd480;
  localparam logic [PITCH_BITS-1:0] ROW_PITCH_RESET   = 13'd640;

  // Control handed from the input stage to the line engine.
  typedef struct packed {
    logic fire;
    logic func;
  } lps_ctrl_t;

endpackage

### src/line_pixel_stepper_core.sv
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid / in_stall    | func, start_x, start_y, end_x, end_y, line_color
// out     | output    | out_valid / out_stall  | pixel_x, pixel_y, pixel_address, pixel_color,
//         |           |                        | visible, last
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One input word is taken every cycle while in_stall is low; a step word's pixel is shown
// once the line engine has written it to the output register. The input register feeds the
// line engine, whose load path holds the single row-times-pitch multiply.
// rst is synchronous and active high: no line is active and the registers take their defaults.
// in_stall rises only while a word waits in the input register and the output register is
// full and stalled; cfg_ready is always high.
module line_pixel_stepper_core
  import lps_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [COLOR_BITS-1:0]        line_color,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [ADDR_BITS-1:0]         pixel_address,
  output logic [COLOR_BITS-1:0]        pixel_color,
  output logic                         visible,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

  // Configuration registers.
  logic                  clip_enable;
  logic [CLIP_BITS-1:0]  clip_width;
  logic [CLIP_BITS-1:0]  clip_height;
  logic [PITCH_BITS-1:0] row_pitch;

  // Input register.
  logic                         in_reg_valid;
  logic                         in_reg_func;
  logic signed [COORD_BITS-1:0] in_reg_start_x;
  logic signed [COORD_BITS-1:0] in_reg_start_y;
  logic signed [COORD_BITS-1:0] in_reg_end_x;
  logic signed [COORD_BITS-1:0] in_reg_end_y;
  logic [COLOR_BITS-1:0]        in_reg_color;

  logic                         in_accept;
  logic                         out_free;
  lps_ctrl_t                    eng_ctrl;
  logic                         eng_emit;
  logic signed [COORD_BITS-1:0] eng_x;
  logic signed [COORD_BITS-1:0] eng_y;
  logic [ADDR_BITS-1:0]         eng_address;
  logic [COLOR_BITS-1:0]        eng_color;
  logic                         eng_visible;
  logic                         eng_last;

  assign cfg_ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enable <= CLIP_ENABLE_RESET;
      clip_width  <= CLIP_WIDTH_RESET;
      clip_height <= CLIP_HEIGHT_RESET;
      row_pitch   <= ROW_PITCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLIP_ENABLE: clip_enable <= cfg_data[0];
        REG_CLIP_WIDTH:  clip_width  <= cfg_data[CLIP_BITS-1:0];
        REG_CLIP_HEIGHT: clip_height <= cfg_data[CLIP_BITS-1:0];
        REG_ROW_PITCH:   row_pitch   <= cfg_data[PITCH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // The held word moves on whenever the output register can take a pixel.
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = in_reg_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    eng_ctrl.fire = in_reg_valid && out_free;
    eng_ctrl.func = in_reg_func;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_accept) begin
      in_reg_valid <= 1'b1;
    end else if (eng_ctrl.fire) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg_func    <= func;
      in_reg_start_x <= start_x;
      in_reg_start_y <= start_y;
      in_reg_end_x   <= end_x;
      in_reg_end_y   <= end_y;
      in_reg_color   <= line_color;
    end
  end

  lps_line_engine #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (eng_ctrl),
    .start_x       (in_reg_start_x),
    .start_y       (in_reg_start_y),
    .end_x         (in_reg_end_x),
    .end_y         (in_reg_end_y),
    .line_color    (in_reg_color),
    .clip_enable   (clip_enable),
    .clip_width    (clip_width),
    .clip_height   (clip_height),
    .row_pitch     (row_pitch),
    .emit          (eng_emit),
    .pixel_x       (eng_x),
    .pixel_y       (eng_y),
    .pixel_address (eng_address),
    .pixel_color   (eng_color),
    .visible       (eng_visible),
    .last          (eng_last)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_emit) begin
      pixel_x       <= eng_x;
      pixel_y       <= eng_y;
      pixel_address <= eng_address;
      pixel_color   <= eng_color;
      visible       <= eng_visible;
      last          <= eng_last;
    end
  end

`ifndef SYNTH
  // An emitted pixel is presented in the next cycle.
  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    eng_emit |=> out_valid)
    else $error("emitted pixel not presented");

  // A pixel held under stall is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !eng_emit)
    else $error("pending pixel overwritten");

  // A stalled input word stays in the input register.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_stall && !in_accept) |=> in_reg_valid)
    else $error("stalled input word was dropped");
`endif

endmodule

### src/lps_line_engine.sv
module lps_line_engine
  import lps_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lps_ctrl_t                    ctrl,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [COLOR_BITS-1:0]        line_color,
  input  logic                         clip_enable,
  input  logic [CLIP_BITS-1:0]         clip_width,
  input  logic [CLIP_BITS-1:0]         clip_height,
  input  logic [PITCH_BITS-1:0]        row_pitch,
  output logic                         emit,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [ADDR_BITS-1:0]         pixel_address,
  output logic [COLOR_BITS-1:0]        pixel_color,
  output logic                         visible,
  output logic                         last
);

  localparam int ERR_BITS  = COORD_BITS + 2;
  localparam int PROD_BITS = COORD_BITS + PITCH_BITS + 1;
  localparam int EXT_BITS  = (ADDR_BITS > PROD_BITS) ? ADDR_BITS : PROD_BITS;
  localparam int CMP_BITS  = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS;

  // Line state.
  logic                         line_active;
  logic signed [COORD_BITS-1:0] current_x;
  logic signed [COORD_BITS-1:0] current_y;
  logic [ADDR_BITS-1:0]         current_address;
  logic [COORD_BITS-1:0]        abs_delta_x;
  logic [COORD_BITS-1:0]        abs_delta_y;
  logic signed [ERR_BITS-1:0]   error_term;
  logic [COORD_BITS-1:0]        steps_left;
  logic                         x_neg;
  logic                         y_neg;
  logic                         y_major;
  logic [COLOR_BITS-1:0]        held_color;

  // Load set-up.
  logic signed [COORD_BITS:0]   load_dx;
  logic signed [COORD_BITS:0]   load_dy;
  logic signed [COORD_BITS:0]   load_dx_abs;
  logic signed [COORD_BITS:0]   load_dy_abs;
  logic [COORD_BITS-1:0]        load_adx;
  logic [COORD_BITS-1:0]        load_ady;
  logic                         load_y_major;
  logic [COORD_BITS-1:0]        load_major;
  logic signed [ERR_BITS-1:0]   load_err;
  logic signed [PROD_BITS-1:0]  load_prod;
  logic [EXT_BITS-1:0]          load_prod_ext;
  logic [ADDR_BITS-1:0]         load_address;

  // Step datapath.
  logic                         step_fire;
  logic                         load_fire;
  logic [COORD_BITS-1:0]        dmaj;
  logic [COORD_BITS-1:0]        dmin;
  logic signed [ERR_BITS:0]     err_sum;
  logic signed [ERR_BITS:0]     err_dec;
  logic                         minor;
  logic                         x_step;
  logic                         y_step;
  logic [ADDR_BITS-1:0]         x_inc;
  logic [ADDR_BITS-1:0]         y_inc;
  logic [ADDR_BITS-1:0]         pitch_ext;
  logic [CMP_BITS-1:0]          x_cmp;
  logic [CMP_BITS-1:0]          y_cmp;

  assign load_fire = ctrl.fire && (ctrl.func == FUNC_LOAD);
  assign step_fire = ctrl.fire && (ctrl.func == FUNC_STEP) && line_active;
  assign emit      = step_fire;

  // Deltas, directions and major axis of a new line.
  always_comb begin
    load_dx      = (COORD_BITS+1)'(end_x) - (COORD_BITS+1)'(start_x);
    load_dy      = (COORD_BITS+1)'(end_y) - (COORD_BITS+1)'(start_y);
    load_dx_abs  = load_dx[COORD_BITS] ? -load_dx : load_dx;
    load_dy_abs  = load_dy[COORD_BITS] ? -load_dy : load_dy;
    load_adx     = load_dx_abs[COORD_BITS-1:0];
    load_ady     = load_dy_abs[COORD_BITS-1:0];
    load_y_major = !(load_adx > load_ady);
    load_major   = load_y_major ? load_ady : load_adx;
    load_err     = -$signed({2'b00, load_major});
  end

  // Start address: signed row times pitch plus column, wrapped to the address width.
  always_comb begin
    load_prod     = $signed(start_y) * $signed({1'b0, row_pitch});
    load_prod_ext = EXT_BITS'(load_prod);
    load_address  = load_prod_ext[ADDR_BITS-1:0] + ADDR_BITS'(start_x);
  end

  // One Bresenham step: error update, axis steps and address increments.
  always_comb begin
    dmaj      = y_major ? abs_delta_y : abs_delta_x;
    dmin      = y_major ? abs_delta_x : abs_delta_y;
    err_sum   = (ERR_BITS+1)'(error_term) + $signed({2'b00, dmin, 1'b0});
    err_dec   = err_sum - $signed({2'b00, dmaj, 1'b0});
    minor     = !err_sum[ERR_BITS];
    x_step    = !y_major || minor;
    y_step    = y_major || minor;
    pitch_ext = ADDR_BITS'(row_pitch);
    x_inc     = x_neg ? {ADDR_BITS{1'b1}} : ADDR_BITS'(1);
    y_inc     = y_neg ? -pitch_ext : pitch_ext;
  end

  // Control state of the line.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (load_fire) begin
      line_active <= 1'b1;
    end else if (step_fire && (steps_left == '0)) begin
      line_active <= 1'b0;
    end
  end

  // Position, error and counters of the line.
  always_ff @(posedge clk) begin
    if (load_fire) begin
      current_x       <= start_x;
      current_y       <= start_y;
      current_address <= load_address;
      abs_delta_x     <= load_adx;
      abs_delta_y     <= load_ady;
      error_term      <= load_err;
      steps_left      <= load_major;
      x_neg           <= load_dx[COORD_BITS];
      y_neg           <= load_dy[COORD_BITS];
      y_major         <= load_y_major;
      held_color      <= line_color;
    end else if (step_fire && (steps_left != '0)) begin
      current_x       <= x_step ? current_x + COORD_BITS'(x_neg ? -1 : 1) : current_x;
      current_y       <= y_step ? current_y + COORD_BITS'(y_neg ? -1 : 1) : current_y;
      current_address <= current_address + (x_step ? x_inc : '0) + (y_step ? y_inc : '0);
      error_term      <= minor ? err_dec[ERR_BITS-1:0] : err_sum[ERR_BITS-1:0];
      steps_left      <= steps_left - COORD_BITS'(1);
    end
  end

  // Pixel at the current position, with the clip test.
  always_comb begin
    x_cmp         = CMP_BITS'($unsigned(current_x));
    y_cmp         = CMP_BITS'($unsigned(current_y));
    pixel_x       = current_x;
    pixel_y       = current_y;
    pixel_address = current_address;
    pixel_color   = held_color;
    last          = (steps_left == '0);
    visible       = !clip_enable ||
                    (!current_x[COORD_BITS-1] && !current_y[COORD_BITS-1] &&
                     (x_cmp < CMP_BITS'(clip_width)) && (y_cmp < CMP_BITS'(clip_height)));
  end

`ifndef SYNTH
  // A line ends only through a step on its final pixel.
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(line_active) |-> $past(step_fire && (steps_left == '0) && !load_fire))
    else $error("line ended without its final pixel");

  // A step that is not final leaves one pixel fewer to go.
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (step_fire && (steps_left != '0)) |=> (steps_left == $past(steps_left) - COORD_BITS'(1)))
    else $error("pixel count did not step down by one");

  // A load always leaves a line active.
  a_load_active: assert property (@(posedge clk) disable iff (rst)
    load_fire |=> line_active)
    else $error("load did not start a line");
`endif

endmodule
